### src/bps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types, codes and decode helpers for the buzzer pattern sequencer.
// ----------------------------------------------------------------------------
package bps_pkg;

	localparam logic [15:0] ALL_ONES = 16'hffff;
	localparam logic [7:0]  COUNT_ENDLESS = 8'hff;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_KEY      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NEAR     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AUTO     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCKED   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNLOCKED = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_FINISH   = 3'd5;

	localparam logic [2:0] PAT_NONE     = 3'd0;
	localparam logic [2:0] PAT_KEY      = 3'd1;
	localparam logic [2:0] PAT_NEAR     = 3'd2;
	localparam logic [2:0] PAT_AUTO     = 3'd3;
	localparam logic [2:0] PAT_LOCKED   = 3'd4;
	localparam logic [2:0] PAT_UNLOCKED = 3'd5;
	localparam logic [2:0] PAT_FINISH   = 3'd6;

	typedef enum logic [1:0] {
		FN_TICK   = 2'd0,
		FN_START  = 2'd1,
		FN_STOP   = 2'd2,
		FN_RESUME = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		PH_SOUND = 3'b001,
		PH_GAP   = 3'b010,
		PH_PEND  = 3'b100
	} phase_t;

	typedef struct packed {
		logic [23:0] key_pattern;
		logic [31:0] near_pattern;
		logic [23:0] auto_pattern;
		logic [23:0] locked_pattern;
		logic [23:0] unlocked_pattern;
		logic [23:0] finish_pattern;
	} cfg_bank_t;

	typedef struct packed {
		logic       buzzer;
		logic [2:0] pattern_now;
	} status_t;

	function automatic logic [31:0] reg_of(input cfg_bank_t bank, input logic [2:0] p);
		logic [31:0] r;
		unique case (p)
			PAT_KEY:      r = {8'd0, bank.key_pattern};
			PAT_NEAR:     r = bank.near_pattern;
			PAT_AUTO:     r = {8'd0, bank.auto_pattern};
			PAT_LOCKED:   r = {8'd0, bank.locked_pattern};
			PAT_UNLOCKED: r = {8'd0, bank.unlocked_pattern};
			PAT_FINISH:   r = {8'd0, bank.finish_pattern};
			default:      r = 32'd0;
		endcase
		return r;
	endfunction

	function automatic logic [15:0] count_of(input logic [31:0] r);
		return (r[7:0] == COUNT_ENDLESS) ? ALL_ONES : {8'd0, r[7:0]};
	endfunction

endpackage
`default_nettype wire

### src/buzzer_pattern_sequencer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// buzzer_pattern_sequencer_top
// Beep pattern sequencer with input register, update logic and result register.
// ----------------------------------------------------------------------------
// Each accepted transaction (tick, start, stop or resume) yields exactly one
// result giving the buzzer level, the active flag and the running pattern
// after that transaction. One transaction is taken every clock cycle while
// results drain; the transaction is held in the input register and its result
// in the result register, around the state update. While a result waits the
// input register still takes one more transaction, then input stalls until
// the result is taken. Pattern registers are written through the
// configuration channel, which is always ready; write them only while no
// transaction is in flight.
module buzzer_pattern_sequencer_top import bps_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [1:0]            func,
	input  wire logic [2:0]            pattern,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       buzzer,
	output logic                       active,
	output logic [2:0]                 pattern_now
);

	cfg_bank_t  bank;
	status_t    status_next;
	status_t    status_s2;
	logic       valid_s1;
	logic [1:0] func_s1;
	logic [2:0] pattern_s1;
	logic       valid_s2;
	logic       adv;

	assign cfg_ready = 1'b1;
	assign adv       = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || adv;

	bps_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.bank     (bank)
	);

	bps_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (adv),
		.func        (func_s1),
		.pattern     (pattern_s1),
		.bank        (bank),
		.status_next (status_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			func_s1    <= func;
			pattern_s1 <= pattern;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s2 <= status_next;
		end
	end

	assign out_valid   = valid_s2;
	assign buzzer      = status_s2.buzzer;
	assign pattern_now = status_s2.pattern_now;
	assign active      = (status_s2.pattern_now != PAT_NONE);

`ifndef SYNTH
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(!valid_s2 || out_ready) |-> in_ready)
		else $error("input stalled while result side can drain");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid)
		else $error("processed transaction produced no result");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(status_s2)))
		else $error("stalled result changed or dropped");
`endif

endmodule
`default_nettype wire

### src/bps_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bps_cfg_regs
// Pattern register bank, written through the configuration channel.
// ----------------------------------------------------------------------------
module bps_cfg_regs import bps_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data,
	output cfg_bank_t                  bank
);

	cfg_bank_t bank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_KEY:      bank_q.key_pattern      <= wr_data[23:0];
				CFG_NEAR:     bank_q.near_pattern     <= wr_data;
				CFG_AUTO:     bank_q.auto_pattern     <= wr_data[23:0];
				CFG_LOCKED:   bank_q.locked_pattern   <= wr_data[23:0];
				CFG_UNLOCKED: bank_q.unlocked_pattern <= wr_data[23:0];
				CFG_FINISH:   bank_q.finish_pattern   <= wr_data[23:0];
				default:      ;
			endcase
		end
	end

	assign bank = bank_q;

endmodule
`default_nettype wire

### src/bps_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bps_core
// Sequencer state and its one-item update: tick, start, stop and resume.
// ----------------------------------------------------------------------------
module bps_core import bps_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       advance,
	input  wire logic [1:0] func,
	input  wire logic [2:0] pattern,
	input  wire cfg_bank_t  bank,
	output status_t         status_next
);

	logic [2:0]  cur_q, cur_d;
	phase_t      phase_q, phase_d;
	logic [15:0] on_q, on_d;
	logic [15:0] off_q, off_d;
	logic [15:0] rep_q, rep_d;
	logic        tog_q, tog_d;
	logic        buz_q, buz_d;

	logic [2:0]  req_pat;
	logic        start_ok;
	logic [31:0] req_reg;
	logic [31:0] run_reg;
	logic [7:0]  near_sel;
	logic [7:0]  gap_len;
	logic [7:0]  on_len;
	logic [15:0] rep_dec;

	assign req_pat = (func_t'(func) == FN_RESUME) ? cur_q : pattern;
	assign start_ok = (req_pat <= PAT_FINISH)
		&& !((cur_q != PAT_NONE) && (req_pat == PAT_KEY))
		&& !(((cur_q == PAT_NEAR) || (cur_q == PAT_AUTO))
			&& ((req_pat == PAT_NEAR) || (req_pat == PAT_AUTO)));
	assign req_reg = reg_of(bank, req_pat);

	assign run_reg  = reg_of(bank, cur_q);
	assign near_sel = tog_q ? run_reg[23:16] : run_reg[15:8];
	assign gap_len  = (cur_q == PAT_NEAR) ? near_sel : run_reg[15:8];
	assign on_len   = (cur_q == PAT_NEAR) ? near_sel : run_reg[23:16];
	assign rep_dec  = ((rep_q != ALL_ONES) && (rep_q != 16'd0)) ? rep_q - 16'd1 : rep_q;

	always_comb begin
		cur_d   = cur_q;
		phase_d = phase_q;
		on_d    = on_q;
		off_d   = off_q;
		rep_d   = rep_q;
		tog_d   = tog_q;
		buz_d   = buz_q;
		unique case (func_t'(func))
			FN_TICK: begin
				if (cur_q != PAT_NONE) begin
					unique case (phase_q)
						PH_SOUND: begin
							if (on_q == 16'd0) begin
								buz_d = 1'b0;
								on_d  = ALL_ONES;
								if (rep_q != 16'd0) begin
									off_d   = {8'd0, gap_len};
									tog_d   = ~tog_q;
									phase_d = PH_GAP;
								end else begin
									off_d   = ALL_ONES;
									cur_d   = PAT_NONE;
									phase_d = PH_SOUND;
								end
							end else begin
								on_d = on_q - 16'd1;
							end
						end
						PH_GAP: begin
							if (off_q == 16'd0) begin
								off_d = ALL_ONES;
								rep_d = rep_dec;
								if (rep_dec != 16'd0) begin
									buz_d   = 1'b1;
									phase_d = PH_SOUND;
									on_d    = {8'd0, on_len};
								end else begin
									on_d    = ALL_ONES;
									cur_d   = PAT_NONE;
									phase_d = PH_SOUND;
								end
							end else begin
								off_d = off_q - 16'd1;
							end
						end
						PH_PEND: begin
							buz_d   = 1'b1;
							tog_d   = 1'b0;
							phase_d = PH_SOUND;
						end
						default: ;
					endcase
				end
			end
			FN_START, FN_RESUME: begin
				if (start_ok) begin
					if (req_pat == PAT_NONE) begin
						cur_d   = PAT_NONE;
						phase_d = PH_SOUND;
						on_d    = ALL_ONES;
						off_d   = ALL_ONES;
						buz_d   = 1'b0;
					end else begin
						cur_d   = req_pat;
						phase_d = PH_PEND;
						off_d   = ALL_ONES;
						on_d    = (req_pat == PAT_NEAR) ? {8'd0, req_reg[31:24]}
							: {8'd0, req_reg[23:16]};
						rep_d   = count_of(req_reg);
						if (req_pat != PAT_NEAR) begin
							buz_d = 1'b1;
						end
					end
				end
			end
			FN_STOP: begin
				cur_d   = PAT_NONE;
				phase_d = PH_SOUND;
				on_d    = ALL_ONES;
				off_d   = ALL_ONES;
				rep_d   = ALL_ONES;
				buz_d   = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= PAT_NONE;
			phase_q <= PH_SOUND;
			on_q    <= ALL_ONES;
			off_q   <= ALL_ONES;
			rep_q   <= 16'd0;
			tog_q   <= 1'b0;
			buz_q   <= 1'b0;
		end else if (advance) begin
			cur_q   <= cur_d;
			phase_q <= phase_d;
			on_q    <= on_d;
			off_q   <= off_d;
			rep_q   <= rep_d;
			tog_q   <= tog_d;
			buz_q   <= buz_d;
		end
	end

	assign status_next.buzzer      = buz_d;
	assign status_next.pattern_now = cur_d;

endmodule
`default_nettype wire

### dv/tb_buzzer_pattern_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_buzzer_pattern_sequencer_top
// Self-checking bench for the buzzer pattern sequencer. A scoreboard class
// tracks the pattern state, predicts the buzzer status after every accepted
// transaction and compares it with each result in order. Stimulus is a short
// directed run through the start, refusal, stop and resume cases, followed by
// random tick and command traffic under several pattern settings and
// handshake idle mixes, with one long output hold-off and one drain pause.
// ----------------------------------------------------------------------------
module tb_buzzer_pattern_sequencer_top;
	import bps_pkg::*;

	localparam logic [2:0] PAT_UNUSED = 3'd7;
	localparam int CYCLE_LIMIT = 400000;
	localparam int NUM_PHASES = 6;
	localparam int ITEMS_PER_PHASE = 255;

	typedef enum int {STY_SMALL, STY_ONES, STY_ZERO, STY_ENDLESS, STY_WIDE} cfg_style_t;

	typedef struct packed {
		logic       buzzer;
		logic       active;
		logic [2:0] pattern_now;
	} beep_status_t;

	class beep_scoreboard;
		logic [31:0] bank [6];
		logic [2:0] cur;
		phase_t ph;
		logic [15:0] on_left;
		logic [15:0] off_left;
		logic [15:0] reps;
		logic toggle;
		logic level;
		beep_status_t pending_status[$];
		int errors;

		function new();
			foreach (bank[i]) bank[i] = '0;
			cur = PAT_NONE;
			ph = PH_SOUND;
			on_left = ALL_ONES;
			off_left = ALL_ONES;
			reps = '0;
			toggle = 1'b0;
			level = 1'b0;
			errors = 0;
		endfunction

		function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
			if (idx == CFG_NEAR) begin
				bank[idx] = data;
			end else if (idx <= CFG_FINISH) begin
				bank[idx] = {8'd0, data[23:0]};
			end
		endfunction

		function logic [31:0] word_of(input logic [2:0] p);
			case (p)
				PAT_KEY:      return bank[CFG_KEY];
				PAT_NEAR:     return bank[CFG_NEAR];
				PAT_AUTO:     return bank[CFG_AUTO];
				PAT_LOCKED:   return bank[CFG_LOCKED];
				PAT_UNLOCKED: return bank[CFG_UNLOCKED];
				PAT_FINISH:   return bank[CFG_FINISH];
				default:      return '0;
			endcase
		endfunction

		function logic [15:0] span(input logic gap);
			logic [31:0] w;
			w = word_of(cur);
			if (cur == PAT_NEAR) return toggle ? {8'd0, w[23:16]} : {8'd0, w[15:8]};
			if (cur >= PAT_KEY && cur <= PAT_FINISH) return gap ? {8'd0, w[15:8]} : {8'd0, w[23:16]};
			return '0;
		endfunction

		function void go_idle();
			cur = PAT_NONE;
			ph = PH_SOUND;
		endfunction

		function void launch(input logic [2:0] p);
			logic [31:0] w;
			w = word_of(p);
			if (p > PAT_FINISH) return;
			if (cur != PAT_NONE && p == PAT_KEY) return;
			if ((cur == PAT_NEAR || cur == PAT_AUTO) && (p == PAT_NEAR || p == PAT_AUTO)) return;
			if (p == PAT_NONE) begin
				go_idle();
				on_left = ALL_ONES;
				off_left = ALL_ONES;
				level = 1'b0;
				return;
			end
			cur = p;
			ph = PH_PEND;
			off_left = ALL_ONES;
			on_left = (p == PAT_NEAR) ? {8'd0, w[31:24]} : {8'd0, w[23:16]};
			reps = (w[7:0] == COUNT_ENDLESS) ? ALL_ONES : {8'd0, w[7:0]};
			if (p != PAT_NEAR) level = 1'b1;
		endfunction

		function void advance_tick();
			if (cur == PAT_NONE) return;
			case (ph)
				PH_SOUND: begin
					if (on_left == 16'd0) begin
						level = 1'b0;
						on_left = ALL_ONES;
						if (reps != 16'd0) begin
							off_left = span(1'b1);
							toggle = ~toggle;
							ph = PH_GAP;
						end else begin
							off_left = ALL_ONES;
							go_idle();
						end
					end else begin
						on_left = on_left - 16'd1;
					end
				end
				PH_GAP: begin
					if (off_left == 16'd0) begin
						off_left = ALL_ONES;
						if (reps != ALL_ONES && reps != 16'd0) reps = reps - 16'd1;
						if (reps != 16'd0) begin
							level = 1'b1;
							ph = PH_SOUND;
							on_left = span(1'b0);
						end else begin
							on_left = ALL_ONES;
							go_idle();
						end
					end else begin
						off_left = off_left - 16'd1;
					end
				end
				PH_PEND: begin
					level = 1'b1;
					toggle = 1'b0;
					ph = PH_SOUND;
				end
				default: ;
			endcase
		endfunction

		function void note_transaction(input logic [1:0] f, input logic [2:0] p);
			case (func_t'(f))
				FN_TICK:   advance_tick();
				FN_START:  launch(p);
				FN_STOP: begin
					go_idle();
					off_left = ALL_ONES;
					on_left = ALL_ONES;
					reps = ALL_ONES;
					level = 1'b0;
				end
				FN_RESUME: launch(cur);
				default: ;
			endcase
			pending_status.push_back('{buzzer: level, active: (cur != PAT_NONE),
				pattern_now: cur});
		endfunction

		function void check_result(input logic b, input logic a, input logic [2:0] pn);
			beep_status_t exp_st;
			if (pending_status.size() == 0) begin
				$display("%0t: unexpected result buzzer %0b active %0b pattern_now %0d",
					$time, b, a, pn);
				errors++;
				return;
			end
			exp_st = pending_status.pop_front();
			if (b !== exp_st.buzzer) begin
				$display("%0t: buzzer expected %0b actual %0b", $time, exp_st.buzzer, b);
				errors++;
			end
			if (a !== exp_st.active) begin
				$display("%0t: active expected %0b actual %0b", $time, exp_st.active, a);
				errors++;
			end
			if (pn !== exp_st.pattern_now) begin
				$display("%0t: pattern_now expected %0d actual %0d", $time,
					exp_st.pattern_now, pn);
				errors++;
			end
		endfunction

		function int waiting();
			return pending_status.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [1:0]            func;
	logic [2:0]            pattern;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  out_valid;
	logic                  out_ready;
	logic                  buzzer;
	logic                  active;
	logic [2:0]            pattern_now;

	beep_scoreboard sb = new();
	logic [31:0] pattern_bank [6];
	int send_idle_pct;
	int recv_stall_pct;
	int hold_request;
	int hold_left;
	int cycle_count;

	buzzer_pattern_sequencer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.pattern(pattern),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.buzzer(buzzer),
		.active(active),
		.pattern_now(pattern_now)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Accept results; hold off for a requested stretch, else stall at random.
	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_ready)
			sb.check_result(buzzer, active, pattern_now);
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	task automatic send_item(input func_t f, input logic [2:0] p);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		pattern <= p;
		do @(posedge clk); while (!in_ready);
		sb.note_transaction(f, p);
	endtask

	task automatic write_bank();
		for (int i = CFG_KEY; i <= CFG_FINISH; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= i[CFG_IDX_W-1:0];
			cfg_data <= pattern_bank[i];
			do @(posedge clk); while (!cfg_ready);
			sb.set_reg(i[CFG_IDX_W-1:0], pattern_bank[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	// Drop valid and drain every outstanding transaction.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.waiting() != 0);
	endtask

	function automatic logic [31:0] make_word(input cfg_style_t style);
		logic [31:0] w;
		w = {8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
			8'($urandom_range(0, 3)), 8'($urandom_range(0, 3))};
		case (style)
			STY_ONES:    w = 32'hffff_ffff;
			STY_ZERO:    w = '0;
			STY_ENDLESS: w[7:0] = COUNT_ENDLESS;
			STY_WIDE:    w = $urandom();
			default: ;
		endcase
		return w;
	endfunction

	task automatic run_random(input int phase_num);
		int r;
		logic [2:0] p;
		for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
			if (phase_num == 2 && k == 100) hold_request = 300;
			if (phase_num == 4 && k == 120) drain();
			r = $urandom_range(0, 99);
			p = 3'($urandom_range(0, 7));
			if (r < 62) begin
				send_item(FN_TICK, p);
			end else if (r < 78) begin
				send_item(FN_START, 3'($urandom_range(PAT_KEY, PAT_FINISH)));
			end else if (r < 82) begin
				send_item(FN_START, ($urandom_range(0, 1) != 0) ? PAT_NONE : PAT_UNUSED);
			end else if (r < 90) begin
				send_item(FN_RESUME, p);
			end else begin
				send_item(FN_STOP, p);
			end
		end
	endtask

	initial begin
		cfg_style_t style;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		func <= FN_TICK;
		pattern <= PAT_NONE;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_KEY;
		cfg_data <= '0;
		out_ready <= 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 0;
		hold_left = 0;
		cycle_count = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		pattern_bank[CFG_KEY] = 32'h0002_0103;
		pattern_bank[CFG_NEAR] = 32'h0302_0102;
		pattern_bank[CFG_AUTO] = 32'h0001_01ff;
		pattern_bank[CFG_LOCKED] = 32'h0000_0000;
		pattern_bank[CFG_UNLOCKED] = 32'h0001_0100;
		pattern_bank[CFG_FINISH] = 32'h00ff_ffff;
		write_bank();

		send_item(FN_START, PAT_NONE);
		send_item(FN_START, PAT_KEY);
		send_item(FN_START, PAT_KEY);
		repeat (2) send_item(FN_TICK, PAT_NONE);
		send_item(FN_START, PAT_NEAR);
		send_item(FN_START, PAT_AUTO);
		repeat (4) send_item(FN_TICK, PAT_UNUSED);
		send_item(FN_RESUME, PAT_NONE);
		send_item(FN_STOP, PAT_NONE);
		send_item(FN_RESUME, PAT_KEY);
		send_item(FN_START, PAT_AUTO);
		repeat (3) send_item(FN_TICK, PAT_NONE);
		send_item(FN_START, PAT_UNUSED);
		send_item(FN_START, PAT_NONE);
		send_item(FN_START, PAT_LOCKED);
		repeat (2) send_item(FN_TICK, PAT_NONE);
		send_item(FN_START, PAT_FINISH);
		send_item(FN_RESUME, PAT_NONE);
		send_item(FN_STOP, PAT_UNUSED);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain();
			repeat (4) @(posedge clk);
			case (ph)
				0: style = STY_SMALL;
				1: style = STY_ONES;
				2: style = STY_ENDLESS;
				3: style = STY_ZERO;
				4: style = STY_WIDE;
				default: style = STY_SMALL;
			endcase
			foreach (pattern_bank[i]) pattern_bank[i] = make_word(style);
			write_bank();
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
				default: begin send_idle_pct = 35; recv_stall_pct = 35; end
			endcase
			run_random(ph);
		end

		drain();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.waiting() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

### buzzer_pattern_sequencer_top.f
src/bps_pkg.sv
src/bps_cfg_regs.sv
src/bps_core.sv
src/buzzer_pattern_sequencer_top.sv
dv/tb_buzzer_pattern_sequencer_top.sv
